[src/pcc_pkg.sv]
// ============================================================================
// pcc_pkg: shared types and constants of the presence change cache
// Field widths, report kind codes and the structs that run along the row of
// cache cells.
// ============================================================================
package pcc_pkg;

  localparam int CACHE_ENTRIES_DEF = 16;

  localparam int ADDR_W = 16;
  localparam int PRES_W = 2;
  localparam int KIND_W = 2;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 8;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [KIND_W-1:0] KIND_NONE           = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OWN_UNICAST    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOTE_UNICAST = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REMOTE_CHANGED = 2'd3;

  // Register index of local_address; the index is paddr[2].
  localparam logic REG_LOCAL_ADDRESS = 1'b0;

  // Lookup flags rippling from cell to cell.
  typedef struct packed {
    logic hit;    // some earlier cell holds the queried address
    logic same;   // the first matching cell holds the same presence
    logic empty;  // some earlier cell is empty
  } chain_t;

  // Write command broadcast to the row in the commit cycle.
  typedef struct packed {
    logic write_hit;
    logic write_empty;
    logic write_victim;
  } commit_t;

endpackage

[src/pcc_cell.sv]
// ============================================================================
// pcc_cell: one entry of the presence cache
// Holds an address and a presence, compares them with the broadcast query and
// passes the lookup flags on to the next cell.
// ============================================================================
module pcc_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       lookup,
  input  logic [pcc_pkg::ADDR_W-1:0] query_addr,
  input  logic [pcc_pkg::PRES_W-1:0] query_pres,
  input  pcc_pkg::chain_t            chain_in,
  output pcc_pkg::chain_t            chain_out,
  input  pcc_pkg::commit_t           commit,
  input  logic                       victim_sel,
  output logic                       first_hit,
  output logic                       first_empty
);

  logic [pcc_pkg::ADDR_W-1:0] addr;
  logic [pcc_pkg::PRES_W-1:0] pres;
  logic                       hit_here;
  logic                       empty_here;
  logic                       write_en;

  assign hit_here   = (addr == query_addr);
  assign empty_here = (addr == '0);

  always_comb begin
    chain_out.hit   = chain_in.hit | hit_here;
    chain_out.same  = chain_in.hit ? chain_in.same : (hit_here & (pres == query_pres));
    chain_out.empty = chain_in.empty | empty_here;
  end

  assign write_en = (commit.write_hit & first_hit) | (commit.write_empty & first_empty) |
                    (commit.write_victim & victim_sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      addr        <= '0;
      pres        <= '0;
      first_hit   <= 1'b0;
      first_empty <= 1'b0;
    end else begin
      if (lookup) begin
        first_hit   <= hit_here & ~chain_in.hit;
        first_empty <= empty_here & ~chain_in.empty;
      end
      if (write_en) begin
        addr <= query_addr;
        pres <= query_pres;
      end
    end
  end

endmodule

[src/presence_change_cache.sv]
// ============================================================================
// presence_change_cache: presence report classifier with a small cache
// Classifies presence reports and remembers the last presence of remote
// nodes in a row of associative cache cells.
// ============================================================================
// One report is handled at a time. The word is captured at its accepting
// edge, which ends the idle cycle. In the following lookup cycle the query
// ripples through the row of CACHE_ENTRIES cells. The commit cycle after it
// writes the chosen cell and loads the result word, and the next word can
// be accepted once the machine is back in idle. The commit waits while an
// earlier result has not been taken. A report from the local node gives
// kind 1 when sent to a unicast destination (1 to 0x7FFF) and kind 0
// otherwise. A remote unicast report gives kind 2. Any other remote report
// is looked up by source address. It gives kind 3 when its presence is new
// or changed, and the presence is then stored in the first matching cell,
// else in the first empty cell (address zero), else in a round-robin
// victim. The cache is empty after reset. local_address is written through
// the APB port at byte address 0; the user must write it only while no
// report is in flight, and the block itself does not enforce this.
// ============================================================================
module presence_change_cache #(
  parameter int CACHE_ENTRIES = pcc_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // s_tdata: source_address [15:0], dest_address [31:16], presence [33:32]
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [pcc_pkg::S_TDATA_W-1:0] s_tdata,
  // m_tdata: report_kind [1:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [pcc_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcc_pkg::PADDR_W-1:0]   paddr,
  input  logic [pcc_pkg::PDATA_W-1:0]   pwdata,
  output logic [pcc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int IDX_W = $clog2(CACHE_ENTRIES);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOK   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0]                 state;
  logic [1:0]                 state_next;

  logic [pcc_pkg::ADDR_W-1:0] local_address;
  logic [pcc_pkg::ADDR_W-1:0] q_src;
  logic [pcc_pkg::ADDR_W-1:0] q_dst;
  logic [pcc_pkg::PRES_W-1:0] q_pres;
  logic [IDX_W-1:0]           victim_ptr;

  // Classification, settled in the lookup cycle.
  logic [pcc_pkg::KIND_W-1:0] pre_kind;
  logic                       group;
  logic                       look_hit;
  logic                       look_same;
  logic                       look_empty;

  logic [pcc_pkg::KIND_W-1:0] out_kind;

  pcc_pkg::chain_t            chain [CACHE_ENTRIES+1];
  pcc_pkg::commit_t           commit;
  logic [CACHE_ENTRIES-1:0]   hit_vec;
  logic [CACHE_ENTRIES-1:0]   empty_vec;

  logic                       own;
  logic                       unicast;
  logic                       out_free;
  logic                       do_commit;
  logic                       changed;

  // Configuration port: one register, writes complete in the access phase.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == pcc_pkg::REG_LOCAL_ADDRESS) ?
                  {{(pcc_pkg::PDATA_W-pcc_pkg::ADDR_W){1'b0}}, local_address} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_address <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == pcc_pkg::REG_LOCAL_ADDRESS) begin
      local_address <= pwdata[pcc_pkg::ADDR_W-1:0];
    end
  end

  assign s_tready = (state == S_IDLE);

  // A destination is unicast when it is nonzero and its top bit is clear.
  assign own     = (q_src == local_address);
  assign unicast = (q_dst != '0) && !q_dst[pcc_pkg::ADDR_W-1];

  assign out_free  = !m_tvalid || m_tready;
  assign do_commit = (state == S_COMMIT) && out_free;

  // Only a group report with a new or different presence touches the cache.
  assign changed = group && !(look_hit && look_same);

  always_comb begin
    commit.write_hit    = do_commit && changed && look_hit;
    commit.write_empty  = do_commit && changed && !look_hit && look_empty;
    commit.write_victim = do_commit && changed && !look_hit && !look_empty;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_LOOK;
      end
      S_LOOK: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      victim_ptr <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (commit.write_victim) begin
        victim_ptr <= (victim_ptr == IDX_W'(CACHE_ENTRIES - 1)) ? '0 :
                      victim_ptr + IDX_W'(1);
      end
      if (do_commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      q_src  <= s_tdata[15:0];
      q_dst  <= s_tdata[31:16];
      q_pres <= s_tdata[33:32];
    end
    if (state == S_LOOK) begin
      look_hit   <= chain[CACHE_ENTRIES].hit;
      look_same  <= chain[CACHE_ENTRIES].same;
      look_empty <= chain[CACHE_ENTRIES].empty;
      group      <= !own && !unicast;
      if (own) begin
        pre_kind <= unicast ? pcc_pkg::KIND_OWN_UNICAST : pcc_pkg::KIND_NONE;
      end else begin
        pre_kind <= unicast ? pcc_pkg::KIND_REMOTE_UNICAST : pcc_pkg::KIND_NONE;
      end
    end
    if (do_commit) begin
      out_kind <= changed ? pcc_pkg::KIND_REMOTE_CHANGED : pre_kind;
    end
  end

  assign m_tdata = {{(pcc_pkg::M_TDATA_W-pcc_pkg::KIND_W){1'b0}}, out_kind};

  // The row of cells; the lookup flags enter at cell 0 cleared.
  assign chain[0] = '0;

  for (genvar i = 0; i < CACHE_ENTRIES; i++) begin : g_cell
    pcc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .lookup     (state == S_LOOK),
      .query_addr (q_src),
      .query_pres (q_pres),
      .chain_in   (chain[i]),
      .chain_out  (chain[i+1]),
      .commit     (commit),
      .victim_sel (victim_ptr == IDX_W'(i)),
      .first_hit  (hit_vec[i]),
      .first_empty(empty_vec[i])
    );
  end

  // At most one cell may claim to be the first match or the first empty one.
  a_hit_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(hit_vec))
    else $error("more than one cell marked as first match");

  a_empty_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(empty_vec))
    else $error("more than one cell marked as first empty");

  a_victim_range: assert property (@(posedge clk) disable iff (rst)
    victim_ptr <= IDX_W'(CACHE_ENTRIES - 1))
    else $error("victim pointer out of range");

  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_LOOK))
    else $error("accepted word did not start a lookup");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_COMMIT))
    else $error("result word appeared outside a commit");

endmodule
